// ===== rtl/bcc_pkg.sv =====
// Shared types, constants and coefficient decode functions for the
// barometer coefficient compensation block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bcc_pkg;

  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 3;

  // Decoded coefficient widths, all two's complement in Q22.
  localparam int A0_W       = 35;
  localparam int B1_W       = 25;
  localparam int B2_W       = 24;
  localparam int C12_W      = 14;

  // pcomp needs ADC_BITS plus this many bits to hold its full range.
  localparam int PCOMP_EXTRA = 28;
  localparam int Q22_FRAC    = 22;
  localparam int LO_SPLIT    = 20;

  localparam int Q22_W      = 38;
  localparam int CENTI_W    = 21;

  localparam int SCALE_W    = 17;
  localparam logic signed [SCALE_W-1:0] SCALE_NUM = 17'sd65000;
  localparam logic [SCALE_W-2:0]        SCALE_MAG = 16'd65000;

  // The divider works on a biased, clamped value: quotients span 0 to 2^22.
  localparam int Q_HALF_LOG2 = 21;
  localparam int Q_W         = 23;
  localparam int CENTI_BIAS  = 50000;
  localparam int FOLDS_PER_STAGE = 2;

  // Accept edge to the edge at which the result word is sampled.
  localparam int PIPE_DEPTH = 10;

  localparam logic signed [Q22_W-1:0]   Q22_MAX   = {1'b0, {(Q22_W-1){1'b1}}};
  localparam logic signed [Q22_W-1:0]   Q22_MIN   = {1'b1, {(Q22_W-1){1'b0}}};
  localparam logic signed [CENTI_W-1:0] CENTI_MAX = {1'b0, {(CENTI_W-1){1'b1}}};
  localparam logic signed [CENTI_W-1:0] CENTI_MIN = {1'b1, {(CENTI_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET  = 3'd0,
    CFG_P_SLOPE = 3'd1,
    CFG_T_SLOPE = 3'd2,
    CFG_CROSS   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [A0_W-1:0]  a0;
    logic signed [B1_W-1:0]  b1;
    logic signed [B2_W-1:0]  b2;
    logic signed [C12_W-1:0] c12;
  } coeff_t;

  // Magnitude bits 14:0 of a two's complement word.
  function automatic logic [14:0] coeff_mag(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] m;
    m = w[WORD_W-1] ? (~w + WORD_W'(1)) : w;
    return m[14:0];
  endfunction

  function automatic logic signed [A0_W-1:0] dec_a0(input logic [WORD_W-1:0] w);
    logic signed [A0_W-1:0] v;
    v = $signed({1'b0, coeff_mag(w), 19'd0});
    return w[WORD_W-1] ? -v : v;
  endfunction

  function automatic logic signed [B1_W-1:0] dec_b1(input logic [WORD_W-1:0] w);
    logic signed [B1_W-1:0] v;
    v = $signed({1'b0, coeff_mag(w), 9'd0});
    return w[WORD_W-1] ? -v : v;
  endfunction

  function automatic logic signed [B2_W-1:0] dec_b2(input logic [WORD_W-1:0] w);
    logic signed [B2_W-1:0] v;
    v = $signed({1'b0, coeff_mag(w), 8'd0});
    return w[WORD_W-1] ? -v : v;
  endfunction

  function automatic logic signed [C12_W-1:0] dec_c12(input logic [WORD_W-1:0] w);
    logic [14:0]             m;
    logic signed [C12_W-1:0] v;
    m = coeff_mag(w);
    v = $signed({1'b0, m[14:2]});
    return w[WORD_W-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/barometer_coefficient_compensation.sv =====
// Top level of the barometer coefficient compensation block.
// Depends on bcc_pkg, bcc_coeff, bcc_poly, bcc_scale and bcc_div.
`default_nettype none

// The block turns one raw pressure and temperature word pair into the
// compensated pressure count pcomp = a0 + (b1 + c12*t)*p + b2*t, exact in Q22,
// and into the pressure in hundredths of hPa, pcomp*65000/(2^ADC_BITS-1)
// + 50000 rounded toward negative infinity. The counts p and t are the top
// ADC_BITS bits of each word. The four coefficient words are written through
// the cfg port (index 0 a0, 1 b1, 2 b2, 3 c12; other indexes are ignored) and
// are decoded into Q22 as they are written; they may only change while no
// word is in flight. The block takes a new word pair in every clock cycle:
// busy never rises, and a word pair is taken whenever start is high. Each
// result word appears on the out_ ports for one cycle with out_valid high,
// in input order, after it has passed through every stage of the pipeline:
// three stages for the polynomial, three for the scaling by 65000 and the
// clamp, and four for the folding divider by 2^ADC_BITS-1, its final
// correction and the output saturation. The receiver cannot stall the
// block, so a result word must be taken in the cycle it is shown. Between
// strobes the out_ fields hold the last word. Both outputs saturate to
// their widths where a larger ADC_BITS could push them out of range.
module barometer_coefficient_compensation
  import bcc_pkg::*;
#(
  parameter int ADC_BITS = 10
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input word: taken at an edge with start high and busy low.
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [WORD_W-1:0]      in_pressure_adc_word,
  input  wire logic [WORD_W-1:0]      in_temperature_adc_word,
  // Result word: one cycle, marked by out_valid.
  output logic                        out_valid,
  output logic signed [Q22_W-1:0]     out_compensated_q22,
  output logic signed [CENTI_W-1:0]   out_pressure_centi_hpa,
  // Coefficient writes.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_wdata
);

  localparam int PCOMP_W = ADC_BITS + PCOMP_EXTRA;
  localparam int UW      = Q22_FRAC + ADC_BITS;

  coeff_t                    coeff;
  logic                      in_go;
  logic                      pcomp_valid;
  logic signed [PCOMP_W-1:0] pcomp;
  logic                      scaled_valid;
  logic [UW-1:0]             scaled;
  logic signed [Q22_W-1:0]   q22_sat;

  // Every stage advances in every cycle, so there is never a reason to refuse.
  assign busy  = 1'b0;
  assign in_go = start && !busy;

  bcc_coeff u_coeff (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coeff     (coeff)
  );

  // Stages 1 to 3: temperature products, slope times pressure, final sum.
  bcc_poly #(.ADC_BITS(ADC_BITS)) u_poly (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_go            (in_go),
    .pressure_word    (in_pressure_adc_word),
    .temperature_word (in_temperature_adc_word),
    .coeff            (coeff),
    .pcomp_valid      (pcomp_valid),
    .pcomp            (pcomp)
  );

  // Stages 4 to 6: times 65000 in two partial products, floor by 2^22,
  // clamp and bias; the Q22 output is saturated alongside.
  bcc_scale #(.ADC_BITS(ADC_BITS)) u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .pcomp_valid  (pcomp_valid),
    .pcomp        (pcomp),
    .scaled_valid (scaled_valid),
    .scaled       (scaled),
    .q22_sat      (q22_sat)
  );

  // Stages 7 to 10: two folds per stage, correction, bias and saturation.
  bcc_div #(.ADC_BITS(ADC_BITS)) u_div (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .scaled_valid           (scaled_valid),
    .scaled                 (scaled),
    .q22_sat                (q22_sat),
    .out_valid              (out_valid),
    .out_compensated_q22    (out_compensated_q22),
    .out_pressure_centi_hpa (out_pressure_centi_hpa)
  );

endmodule

`default_nettype wire

// ===== rtl/bcc_coeff.sv =====
// Coefficient register file: decodes each written word into Q22 at write time.
// Depends on bcc_pkg.
`default_nettype none

module bcc_coeff
  import bcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  output coeff_t                    coeff
);

  coeff_t coeff_r, coeff_nxt;

  always_comb begin
    coeff_nxt = coeff_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET:  coeff_nxt.a0  = dec_a0(cfg_wdata);
        CFG_P_SLOPE: coeff_nxt.b1  = dec_b1(cfg_wdata);
        CFG_T_SLOPE: coeff_nxt.b2  = dec_b2(cfg_wdata);
        CFG_CROSS:   coeff_nxt.c12 = dec_c12(cfg_wdata);
        default:     coeff_nxt = coeff_r;
      endcase
    end
  end

  // A zero word decodes to zero, so clearing the decoded form is the reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  assign coeff = coeff_r;

endmodule

`default_nettype wire

// ===== rtl/bcc_poly.sv =====
// Polynomial stages: pcomp = a0 + (b1 + c12*t)*p + b2*t over three registers.
// Depends on bcc_pkg.
`default_nettype none

module bcc_poly
  import bcc_pkg::*;
#(
  parameter int ADC_BITS = 10
)(
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_go,
  input  wire logic [WORD_W-1:0]                   pressure_word,
  input  wire logic [WORD_W-1:0]                   temperature_word,
  input  wire coeff_t                              coeff,
  output logic                                     pcomp_valid,
  output logic signed [ADC_BITS+PCOMP_EXTRA-1:0]   pcomp
);

  localparam int PCOMP_W = ADC_BITS + PCOMP_EXTRA;
  localparam int TS_W    = ADC_BITS + 1;
  localparam int CT_W    = C12_W + TS_W;
  localparam int B2T_W   = B2_W + TS_W;
  localparam int SUM_W   = ((B1_W > CT_W) ? B1_W : CT_W) + 1;
  localparam int MUL_W   = SUM_W + TS_W;
  localparam int AB_W    = ((A0_W > B2T_W) ? A0_W : B2T_W) + 1;

  logic [ADC_BITS-1:0]      p_cnt, t_cnt;
  logic signed [TS_W-1:0]   t_s;
  logic signed [CT_W-1:0]   ct;
  logic signed [B2T_W-1:0]  b2t;
  logic signed [SUM_W-1:0]  sum;
  logic signed [MUL_W-1:0]  mul;
  logic signed [AB_W-1:0]   ab;

  logic                     v1_r, v2_r, v3_r;
  logic [ADC_BITS-1:0]      p1_r;
  logic signed [CT_W-1:0]   ct1_r;
  logic signed [B2T_W-1:0]  b2t1_r;
  logic signed [MUL_W-1:0]  mul2_r;
  logic signed [AB_W-1:0]   ab2_r;
  logic signed [PCOMP_W-1:0] pcomp3_r;

  // Counts sit in the top bits of each raw word.
  assign p_cnt = pressure_word[WORD_W-1 -: ADC_BITS];
  assign t_cnt = temperature_word[WORD_W-1 -: ADC_BITS];
  assign t_s   = $signed({1'b0, t_cnt});

  // Stage 1: the two products that depend on the temperature only.
  assign ct  = CT_W'($signed(coeff.c12)) * CT_W'(t_s);
  assign b2t = B2T_W'($signed(coeff.b2)) * B2T_W'(t_s);

  // Stage 2: slope times pressure, and the offset term.
  assign sum = SUM_W'($signed(coeff.b1)) + SUM_W'(ct1_r);
  assign mul = MUL_W'(sum) * MUL_W'($signed({1'b0, p1_r}));
  assign ab  = AB_W'($signed(coeff.a0)) + AB_W'(b2t1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r     <= p_cnt;
    ct1_r    <= ct;
    b2t1_r   <= b2t;
    mul2_r   <= mul;
    ab2_r    <= ab;
    // The true sum always fits PCOMP_W, so dropping upper sign bits is exact.
    pcomp3_r <= PCOMP_W'(mul2_r) + PCOMP_W'(ab2_r);
  end

  assign pcomp_valid = v3_r;
  assign pcomp       = pcomp3_r;

endmodule

`default_nettype wire

// ===== rtl/bcc_scale.sv =====
// Scaling stages: pcomp*65000 floored by 2^22, clamped and biased for the
// divider, plus saturation of the Q22 output. Depends on bcc_pkg.
`default_nettype none

module bcc_scale
  import bcc_pkg::*;
#(
  parameter int ADC_BITS = 10
)(
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               pcomp_valid,
  input  wire logic signed [ADC_BITS+PCOMP_EXTRA-1:0] pcomp,
  output logic                                    scaled_valid,
  output logic [Q22_FRAC+ADC_BITS-1:0]            scaled,
  output logic signed [Q22_W-1:0]                 q22_sat
);

  localparam int PCOMP_W = ADC_BITS + PCOMP_EXTRA;
  localparam int HI_W    = PCOMP_W - LO_SPLIT;
  localparam int HP_W    = HI_W + SCALE_W;
  localparam int LP_W    = LO_SPLIT + SCALE_W - 1;
  localparam int XW      = PCOMP_W + SCALE_W;
  localparam int NW      = XW - Q22_FRAC;
  localparam int VW      = NW + 1;
  localparam int UW      = Q22_FRAC + ADC_BITS;
  localparam int SAT_W   = (PCOMP_W > Q22_W) ? PCOMP_W : Q22_W;
  localparam longint FS  = (longint'(1) << ADC_BITS) - 1;
  localparam longint BIAS = FS << Q_HALF_LOG2;
  localparam logic signed [VW-1:0] BIAS_S = VW'(BIAS);
  localparam logic signed [VW-1:0] SPAN_S = VW'(2 * BIAS);

  logic signed [HI_W-1:0]   hi;
  logic [LO_SPLIT-1:0]      lo;
  logic signed [HP_W-1:0]   hp;
  logic [LP_W-1:0]          lp;
  logic signed [SAT_W-1:0]  pe;
  logic signed [Q22_W-1:0]  q22;
  logic signed [XW-1:0]     x;
  logic signed [VW-1:0]     vb;
  logic [UW-1:0]            u;

  logic                     v4_r, v5_r, v6_r;
  logic signed [HP_W-1:0]   hp4_r;
  logic [LP_W-1:0]          lp4_r;
  logic signed [Q22_W-1:0]  q22_4_r, q22_5_r, q22_6_r;
  logic signed [NW-1:0]     n5_r;
  logic [UW-1:0]            u6_r;

  // Stage 4: the product is split into two partial products of about 20x17.
  assign hi = $signed(pcomp[PCOMP_W-1:LO_SPLIT]);
  assign lo = pcomp[LO_SPLIT-1:0];
  assign hp = HP_W'(hi) * HP_W'(SCALE_NUM);
  assign lp = LP_W'(lo) * LP_W'(SCALE_MAG);

  assign pe = SAT_W'(pcomp);
  always_comb begin
    if (pe > SAT_W'(Q22_MAX)) begin
      q22 = Q22_MAX;
    end else if (pe < SAT_W'(Q22_MIN)) begin
      q22 = Q22_MIN;
    end else begin
      q22 = Q22_W'(pe);
    end
  end

  // Stage 5: recombine and floor by 2^22 with an arithmetic shift.
  assign x = (XW'(hp4_r) <<< LO_SPLIT) + $signed(XW'(lp4_r));

  // Stage 6: beyond plus or minus 2^21 quotients the pressure saturates anyway,
  // so the value is clamped there and biased to be non-negative.
  assign vb = VW'(n5_r) + BIAS_S;
  always_comb begin
    if (vb[VW-1]) begin
      u = '0;
    end else if (vb > SPAN_S) begin
      u = UW'(SPAN_S);
    end else begin
      u = UW'(vb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= pcomp_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    hp4_r   <= hp;
    lp4_r   <= lp;
    q22_4_r <= q22;
    n5_r    <= x[XW-1:Q22_FRAC];
    q22_5_r <= q22_4_r;
    u6_r    <= u;
    q22_6_r <= q22_5_r;
  end

  assign scaled_valid = v6_r;
  assign scaled       = u6_r;
  assign q22_sat      = q22_6_r;

endmodule

`default_nettype wire

// ===== rtl/bcc_div.sv =====
// Divider by 2^ADC_BITS-1 using digit folding, then bias and saturation of
// the pressure output and the output word registers. Depends on bcc_pkg.
`default_nettype none

module bcc_div
  import bcc_pkg::*;
#(
  parameter int ADC_BITS = 10
)(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          scaled_valid,
  input  wire logic [Q22_FRAC+ADC_BITS-1:0]  scaled,
  input  wire logic signed [Q22_W-1:0]       q22_sat,
  output logic                               out_valid,
  output logic signed [Q22_W-1:0]            out_compensated_q22,
  output logic signed [CENTI_W-1:0]          out_pressure_centi_hpa
);

  localparam int UW   = Q22_FRAC + ADC_BITS;
  localparam int VM_W = Q_W;
  localparam int VN_W = ADC_BITS + 1;
  localparam int CW   = Q_W + 1;
  localparam int FS   = (1 << ADC_BITS) - 1;
  localparam int CENTI_OFFSET = (1 << Q_HALF_LOG2) - CENTI_BIAS;

  logic [UW-1:0]            v7;
  logic [Q_W-1:0]           q7;
  logic [VM_W-1:0]          v8;
  logic [Q_W-1:0]           q8;
  logic [Q_W-1:0]           qf;
  logic signed [CW-1:0]     centi_w;
  logic signed [CENTI_W-1:0] centi;

  logic                     v7_r, v8_r, v9_r, out_valid_r;
  logic [VM_W-1:0]          rem7_r;
  logic [Q_W-1:0]           q7_r, q8_r, qf9_r;
  logic [VN_W-1:0]          rem8_r;
  logic signed [Q22_W-1:0]  q22_7_r, q22_8_r, q22_9_r, q22_out_r;
  logic signed [CENTI_W-1:0] centi_out_r;

  // Writing v = a*2^k + b gives v = a*(2^k-1) + (a+b): each fold moves a into
  // the quotient and leaves a remainder about k bits shorter.
  always_comb begin
    v7 = scaled;
    q7 = '0;
    for (int i = 0; i < FOLDS_PER_STAGE; i++) begin
      q7 = q7 + Q_W'(v7 >> ADC_BITS);
      v7 = (v7 >> ADC_BITS) + (v7 & UW'(FS));
    end
  end

  always_comb begin
    v8 = rem7_r;
    q8 = q7_r;
    for (int i = 0; i < FOLDS_PER_STAGE; i++) begin
      q8 = q8 + Q_W'(v8 >> ADC_BITS);
      v8 = (v8 >> ADC_BITS) + (v8 & VM_W'(FS));
    end
  end

  // After four folds the remainder is below 2^(k+1), so at most two more
  // divisor multiples are left in it.
  always_comb begin
    if (rem8_r >= VN_W'(2 * FS)) begin
      qf = q8_r + Q_W'(2);
    end else if (rem8_r >= VN_W'(FS)) begin
      qf = q8_r + Q_W'(1);
    end else begin
      qf = q8_r;
    end
  end

  assign centi_w = $signed({1'b0, qf9_r}) - CW'(CENTI_OFFSET);
  always_comb begin
    if (centi_w > CW'(CENTI_MAX)) begin
      centi = CENTI_MAX;
    end else if (centi_w < CW'(CENTI_MIN)) begin
      centi = CENTI_MIN;
    end else begin
      centi = CENTI_W'(centi_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v7_r        <= scaled_valid;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    rem7_r  <= VM_W'(v7);
    q7_r    <= q7;
    q22_7_r <= q22_sat;
    rem8_r  <= VN_W'(v8);
    q8_r    <= q8;
    q22_8_r <= q22_7_r;
    qf9_r   <= qf;
    q22_9_r <= q22_8_r;
    // The output word holds between strobes.
    if (v9_r) begin
      q22_out_r   <= q22_9_r;
      centi_out_r <= centi;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_compensated_q22    = q22_out_r;
  assign out_pressure_centi_hpa = centi_out_r;

endmodule

`default_nettype wire

// ===== rtl/bcc_checker.sv =====
// Port-level checks on the compensation block's timing and result words,
// bound to the top level. Depends on bcc_pkg.
`default_nettype none

module bcc_checker
  import bcc_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic signed [Q22_W-1:0]     out_compensated_q22,
  input wire logic signed [CENTI_W-1:0]   out_pressure_centi_hpa
);

  localparam logic signed [CENTI_W-1:0] CENTI_ZERO = CENTI_W'(CENTI_BIAS);

  // Every word taken comes out as a result word after the full pipeline depth.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("result word missing after an accepted input word");

  // No result word appears without an input word taken the pipeline depth before.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result word without a matching input word");

  // A negative pcomp always maps below the zero-count pressure, and a
  // non-negative one never does.
  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_compensated_q22[Q22_W-1] == (out_pressure_centi_hpa < CENTI_ZERO)))
    else $error("pressure output disagrees with the sign of pcomp");

endmodule

bind barometer_coefficient_compensation bcc_checker u_bcc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .start                  (start),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_compensated_q22    (out_compensated_q22),
  .out_pressure_centi_hpa (out_pressure_centi_hpa)
);

`default_nettype wire
